### src/tmap_pkg.sv
// Shared types, widths and constants of the touch sample to pixel mapper.
package tmap_pkg;

    localparam int SAMPLE_W     = 12;   // width of the sample field
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int GAIN_W       = 16;
    localparam int OFF_W        = 12;
    localparam int PIX_W        = 9;
    localparam int FRAC_BITS    = 14;
    localparam int PROD_W       = SAMPLE_W + 1 + GAIN_W;
    localparam int SUM_W        = PROD_W - FRAC_BITS + 1;
    localparam int PAIR_LIMIT   = 50;
    localparam int X_MAX        = 319;
    localparam int Y_MAX        = 479;

    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;
    localparam int APB_AW       = 5;
    localparam int APB_DW       = 32;

    localparam logic [GAIN_W-1:0] X_GAIN_RST = GAIN_W'(1311);
    localparam logic [GAIN_W-1:0] Y_GAIN_RST = GAIN_W'(1966);

    typedef enum logic [2:0] {
        REG_X_GAIN      = 3'd0,
        REG_X_OFFSET    = 3'd1,
        REG_Y_GAIN      = 3'd2,
        REG_Y_OFFSET    = 3'd3,
        REG_RECT_LEFT   = 3'd4,
        REG_RECT_TOP    = 3'd5,
        REG_RECT_WIDTH  = 3'd6,
        REG_RECT_HEIGHT = 3'd7
    } t_reg_idx;

    typedef enum logic {
        AXIS_X = 1'b0,
        AXIS_Y = 1'b1
    } t_axis;

    // One complete point: both pair averages.
    typedef struct packed {
        logic [SAMPLE_W-1:0] x_avg;
        logic [SAMPLE_W-1:0] y_avg;
    } t_job;

    typedef struct packed {
        logic signed [GAIN_W-1:0] x_gain;
        logic signed [OFF_W-1:0]  x_offset;
        logic signed [GAIN_W-1:0] y_gain;
        logic signed [OFF_W-1:0]  y_offset;
        logic [PIX_W-1:0]         rect_left;
        logic [PIX_W-1:0]         rect_top;
        logic [PIX_W-1:0]         rect_width;
        logic [PIX_W-1:0]         rect_height;
    } t_cal_cfg;

    // Clamp a signed pixel sum into 0..max.
    function automatic logic [PIX_W-1:0] clamp_pix(logic signed [SUM_W-1:0] v,
                                                   logic [PIX_W-1:0] max);
        logic [PIX_W-1:0] r;
        if (v[SUM_W-1]) begin
            r = '0;
        end else if (unsigned'(v) > SUM_W'(max)) begin
            r = max;
        end else begin
            r = v[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/tmap_front.sv
// Front end: sample pairing, pair rejection, averaging and point assembly.
module tmap_front import tmap_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_axis,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_push,
    output t_job                o_job
);

    logic [SAMPLE_W-1:0] w_mask;
    logic [SAMPLE_W-1:0] w_s;
    logic [SAMPLE_W:0]   w_diff;
    logic [SAMPLE_W:0]   w_sum;
    logic [SAMPLE_W-1:0] w_avg;
    logic                w_pair;
    logic                w_keep;

    logic                r_held, n_held;
    logic                r_axis, n_axis;
    logic [SAMPLE_W-1:0] r_first, n_first;
    logic                r_x_rdy, n_x_rdy;
    logic [SAMPLE_W-1:0] r_x_avg, n_x_avg;

    always_comb begin
        for (int i = 0; i < SAMPLE_W; i++) begin
            w_mask[i] = (i < SAMPLE_BITS);
        end
    end

    assign w_s    = i_sample & w_mask;
    assign w_pair = r_held && (r_axis == i_axis);
    assign w_diff = (r_first > w_s) ? ({1'b0, r_first} - {1'b0, w_s})
                                    : ({1'b0, w_s} - {1'b0, r_first});
    assign w_keep = (w_diff <= (SAMPLE_W+1)'(PAIR_LIMIT));
    assign w_sum  = {1'b0, r_first} + {1'b0, w_s};
    assign w_avg  = w_sum[SAMPLE_W:1];

    always_comb begin
        n_held  = r_held;
        n_axis  = r_axis;
        n_first = r_first;
        n_x_rdy = r_x_rdy;
        n_x_avg = r_x_avg;
        o_push  = 1'b0;
        if (i_accept) begin
            if (!w_pair) begin
                n_held  = 1'b1;
                n_axis  = i_axis;
                n_first = w_s;
            end else begin
                n_held = 1'b0;
                if (w_keep) begin
                    if (i_axis == AXIS_X) begin
                        n_x_avg = w_avg;
                        n_x_rdy = 1'b1;
                    end else if (r_x_rdy) begin
                        n_x_rdy = 1'b0;
                        o_push  = 1'b1;
                    end
                end
            end
        end
    end

    assign o_job.x_avg = r_x_avg;
    assign o_job.y_avg = w_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_axis  <= 1'b0;
            r_first <= '0;
            r_x_rdy <= 1'b0;
            r_x_avg <= '0;
        end else begin
            r_held  <= n_held;
            r_axis  <= n_axis;
            r_first <= n_first;
            r_x_rdy <= n_x_rdy;
            r_x_avg <= n_x_avg;
        end
    end

endmodule

### src/tmap_queue.sv
// Two-word queue between front and back ends.
module tmap_queue import tmap_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_job o_job
);

    logic r_head_v;
    logic r_tail_v;
    t_job r_head;
    t_job r_tail;

    assign o_valid = r_head_v;
    assign o_full  = r_tail_v;
    assign o_job   = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else begin
            case ({i_push, i_pop})
                2'b10: begin
                    if (!r_head_v) begin
                        r_head_v <= 1'b1;
                    end else begin
                        r_tail_v <= 1'b1;
                    end
                end
                2'b01: begin
                    r_head_v <= r_tail_v;
                    r_tail_v <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_pop) begin
            if (r_tail_v) begin
                r_head <= r_tail;
                r_tail <= i_job;
            end else begin
                r_head <= i_job;
            end
        end else if (i_push) begin
            if (!r_head_v) begin
                r_head <= i_job;
            end else begin
                r_tail <= i_job;
            end
        end else if (i_pop) begin
            r_head <= r_tail;
        end
    end

endmodule

### src/tmap_back.sv
// Back end: gain multiply, offset, clamp and rectangle test, two stages.
module tmap_back import tmap_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cal_cfg       i_cfg,
    input  logic           i_valid,
    input  t_job           i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [PIX_W-1:0] o_x_pixel,
    output logic [PIX_W-1:0] o_y_pixel,
    output logic           o_inside
);

    logic w_adv2;
    logic w_ld1;

    logic signed [SAMPLE_W:0]  w_xa;
    logic signed [SAMPLE_W:0]  w_ya;
    logic signed [PROD_W-1:0]  r_px;
    logic signed [PROD_W-1:0]  r_py;
    logic                      r_v1;

    logic signed [PROD_W-FRAC_BITS-1:0] w_qx;
    logic signed [PROD_W-FRAC_BITS-1:0] w_qy;
    logic signed [SUM_W-1:0]            w_sx;
    logic signed [SUM_W-1:0]            w_sy;
    logic [PIX_W-1:0]                   w_xp;
    logic [PIX_W-1:0]                   w_yp;
    logic [PIX_W:0]                     w_right;
    logic [PIX_W:0]                     w_bottom;
    logic                               w_in;

    logic                 r_ov;
    logic [PIX_W-1:0]     r_x;
    logic [PIX_W-1:0]     r_y;
    logic                 r_in;

    assign w_adv2 = !r_ov || i_ready;
    assign w_ld1  = !r_v1 || w_adv2;
    assign o_pop  = i_valid && w_ld1;

    assign w_xa = {1'b0, i_job.x_avg};
    assign w_ya = {1'b0, i_job.y_avg};

    // floor(p / 2^14) is an arithmetic shift
    assign w_qx = r_px[PROD_W-1:FRAC_BITS];
    assign w_qy = r_py[PROD_W-1:FRAC_BITS];
    assign w_sx = SUM_W'(w_qx) + SUM_W'(i_cfg.x_offset);
    assign w_sy = SUM_W'(w_qy) + SUM_W'(i_cfg.y_offset);
    assign w_xp = clamp_pix(w_sx, PIX_W'(X_MAX));
    assign w_yp = clamp_pix(w_sy, PIX_W'(Y_MAX));

    assign w_right  = {1'b0, i_cfg.rect_left} + {1'b0, i_cfg.rect_width};
    assign w_bottom = {1'b0, i_cfg.rect_top} + {1'b0, i_cfg.rect_height};
    assign w_in = (w_xp >= i_cfg.rect_left) && ({1'b0, w_xp} <= w_right) &&
                  (w_yp >= i_cfg.rect_top)  && ({1'b0, w_yp} <= w_bottom);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_ld1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_ov <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_px <= w_xa * i_cfg.x_gain;
            r_py <= w_ya * i_cfg.y_gain;
        end
        if (w_adv2 && r_v1) begin
            r_x  <= w_xp;
            r_y  <= w_yp;
            r_in <= w_in;
        end
    end

    assign o_valid   = r_ov;
    assign o_x_pixel = r_x;
    assign o_y_pixel = r_y;
    assign o_inside  = r_in;

endmodule

### src/touch_sample_to_pixel_mapper.sv
// Top level of the touch sample to pixel mapper: register file and datapath wiring.
//
//  port group   dir  word contents                              handshake
//  -----------  ---  -----------------------------------------  ----------------
//  s (samples)  in   tdata[11:0] sample, tuser axis (0 X, 1 Y)   tvalid & tready
//  m (points)   out  tdata[8:0] x, [17:9] y, tuser inside flag   tvalid & tready
//  apb (cfg)    in   8 registers at 4*index, 32-bit data         psel&penable&pwrite
//
// One sample word per cycle is taken as long as the two-word point queue is
// not full; the queue only fills while the output is stalled.
// A point is registered in the queue head, the multiply register and the
// output register after the sample that completes it; an output stall holds it.
// Reset is synchronous, active low; it clears pairing state, queue and
// pipeline valids and loads the register defaults. No clearing pass.
// Output stalls back up through the pipeline into the queue, never into
// the pairing logic directly.
module touch_sample_to_pixel_mapper import tmap_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF   // ADC bits used, 8..12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [11:0] sample, [15:12] zero
    input  logic                  i_s_tuser,   // [0] axis
    // point stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [8:0] x_pixel, [17:9] y_pixel, [23:18] zero
    output logic                  o_m_tuser,   // [0] inside_res
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    // calibration registers
    logic [GAIN_W-1:0] r_x_gain;
    logic [OFF_W-1:0]  r_x_offset;
    logic [GAIN_W-1:0] r_y_gain;
    logic [OFF_W-1:0]  r_y_offset;
    logic [PIX_W-1:0]  r_rect_left;
    logic [PIX_W-1:0]  r_rect_top;
    logic [PIX_W-1:0]  r_rect_width;
    logic [PIX_W-1:0]  r_rect_height;

    t_reg_idx w_idx;
    logic     w_wr;
    t_cal_cfg w_cfg;

    logic     w_accept;
    logic     w_push;
    t_job     w_push_job;
    logic     w_q_valid;
    logic     w_q_full;
    t_job     w_q_job;
    logic     w_pop;
    logic [PIX_W-1:0] w_x_pixel;
    logic [PIX_W-1:0] w_y_pixel;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gain      <= X_GAIN_RST;
            r_x_offset    <= '0;
            r_y_gain      <= Y_GAIN_RST;
            r_y_offset    <= '0;
            r_rect_left   <= '0;
            r_rect_top    <= '0;
            r_rect_width  <= '0;
            r_rect_height <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_X_GAIN:      r_x_gain      <= pwdata[GAIN_W-1:0];
                REG_X_OFFSET:    r_x_offset    <= pwdata[OFF_W-1:0];
                REG_Y_GAIN:      r_y_gain      <= pwdata[GAIN_W-1:0];
                REG_Y_OFFSET:    r_y_offset    <= pwdata[OFF_W-1:0];
                REG_RECT_LEFT:   r_rect_left   <= pwdata[PIX_W-1:0];
                REG_RECT_TOP:    r_rect_top    <= pwdata[PIX_W-1:0];
                REG_RECT_WIDTH:  r_rect_width  <= pwdata[PIX_W-1:0];
                REG_RECT_HEIGHT: r_rect_height <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // readback, zero extended
    always_comb begin
        case (w_idx)
            REG_X_GAIN:      prdata = APB_DW'(r_x_gain);
            REG_X_OFFSET:    prdata = APB_DW'(r_x_offset);
            REG_Y_GAIN:      prdata = APB_DW'(r_y_gain);
            REG_Y_OFFSET:    prdata = APB_DW'(r_y_offset);
            REG_RECT_LEFT:   prdata = APB_DW'(r_rect_left);
            REG_RECT_TOP:    prdata = APB_DW'(r_rect_top);
            REG_RECT_WIDTH:  prdata = APB_DW'(r_rect_width);
            REG_RECT_HEIGHT: prdata = APB_DW'(r_rect_height);
            default:         prdata = '0;
        endcase
    end

    assign w_cfg.x_gain      = r_x_gain;
    assign w_cfg.x_offset    = r_x_offset;
    assign w_cfg.y_gain      = r_y_gain;
    assign w_cfg.y_offset    = r_y_offset;
    assign w_cfg.rect_left   = r_rect_left;
    assign w_cfg.rect_top    = r_rect_top;
    assign w_cfg.rect_width  = r_rect_width;
    assign w_cfg.rect_height = r_rect_height;

    // the front never pushes into a full queue, since tready drops first
    assign o_s_tready = !w_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    tmap_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_axis   (i_s_tuser),
        .i_sample (i_s_tdata[SAMPLE_W-1:0]),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    tmap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_job   (w_q_job)
    );

    tmap_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (w_q_valid),
        .i_job     (w_q_job),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_x_pixel (w_x_pixel),
        .o_y_pixel (w_y_pixel),
        .o_inside  (o_m_tuser)
    );

    assign o_m_tdata = {(M_TDATA_W - 2*PIX_W)'(0), w_y_pixel, w_x_pixel};

endmodule

### src/tmap_checker.sv
// Port-level checks of the touch sample to pixel mapper, bound to the top level.
module tmap_checker import tmap_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic                 o_m_tuser,
    input logic                 pready
);

    // a stalled point word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled point word changed");

    // coordinates stay on screen
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[PIX_W-1:0] <= PIX_W'(X_MAX)) &&
                       (o_m_tdata[2*PIX_W-1:PIX_W] <= PIX_W'(Y_MAX)))
        else $error("pixel beyond screen");

    // the queue fills only behind a stalled output
    a_full_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no point pending");

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output not cleared by reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind touch_sample_to_pixel_mapper tmap_checker u_tmap_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);

### dv/tmap_point_checker.sv
`timescale 1ns / 1ps
// Point checker: watches the sample, point and register ports, predicts points and compares.
module tmap_point_checker import tmap_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_m_tuser,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [APB_AW-1:0]    i_paddr,
    input  logic [APB_DW-1:0]    i_pwdata,
    output int                   o_fail_count,
    output int                   o_points_owed
);

    typedef struct {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             in_rect;
    } t_point;

    t_cal_cfg            cal;
    logic                pair_open;
    t_axis               open_axis;
    logic [SAMPLE_W-1:0] open_sample;
    logic                x_valid;
    logic [SAMPLE_W-1:0] x_avg;
    t_point              point_q[$];
    int                  fails = 0;

    // floor(avg * gain / 2^14) + offset, clamped to 0..max
    function automatic logic [PIX_W-1:0] scale_to_pixel(input logic [SAMPLE_W-1:0] avg,
                                                        input logic signed [GAIN_W-1:0] gain,
                                                        input logic signed [OFF_W-1:0] offset,
                                                        input int max);
        longint pix;
        pix = ((longint'(avg) * longint'(gain)) >>> FRAC_BITS) + longint'(offset);
        if (pix < 0) begin
            pix = 0;
        end else if (pix > longint'(max)) begin
            pix = longint'(max);
        end
        return PIX_W'(pix);
    endfunction

    always @(posedge i_clk) begin : watch
        t_point              want;
        t_point              got;
        t_axis               ax;
        logic [SAMPLE_W-1:0] smp;
        int                  diff;
        if (!i_rst_n) begin
            cal.x_gain      = X_GAIN_RST;
            cal.x_offset    = '0;
            cal.y_gain      = Y_GAIN_RST;
            cal.y_offset    = '0;
            cal.rect_left   = '0;
            cal.rect_top    = '0;
            cal.rect_width  = '0;
            cal.rect_height = '0;
            pair_open       = 1'b0;
            open_axis       = AXIS_X;
            open_sample     = '0;
            x_valid         = 1'b0;
            x_avg           = '0;
            point_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_AW-1:2]))
                    REG_X_GAIN:      cal.x_gain      = i_pwdata[GAIN_W-1:0];
                    REG_X_OFFSET:    cal.x_offset    = i_pwdata[OFF_W-1:0];
                    REG_Y_GAIN:      cal.y_gain      = i_pwdata[GAIN_W-1:0];
                    REG_Y_OFFSET:    cal.y_offset    = i_pwdata[OFF_W-1:0];
                    REG_RECT_LEFT:   cal.rect_left   = i_pwdata[PIX_W-1:0];
                    REG_RECT_TOP:    cal.rect_top    = i_pwdata[PIX_W-1:0];
                    REG_RECT_WIDTH:  cal.rect_width  = i_pwdata[PIX_W-1:0];
                    REG_RECT_HEIGHT: cal.rect_height = i_pwdata[PIX_W-1:0];
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                got.x       = i_m_tdata[PIX_W-1:0];
                got.y       = i_m_tdata[2*PIX_W-1:PIX_W];
                got.in_rect = i_m_tuser;
                if (point_q.size() == 0) begin
                    $error("unexpected point: x_pixel %0d y_pixel %0d inside_res %0d",
                           got.x, got.y, got.in_rect);
                    fails++;
                end else begin
                    want = point_q.pop_front();
                    if (got.x !== want.x) begin
                        $error("x_pixel: expected %0d, got %0d", want.x, got.x);
                        fails++;
                    end
                    if (got.y !== want.y) begin
                        $error("y_pixel: expected %0d, got %0d", want.y, got.y);
                        fails++;
                    end
                    if (got.in_rect !== want.in_rect) begin
                        $error("inside_res: expected %0d, got %0d", want.in_rect, got.in_rect);
                        fails++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                ax  = t_axis'(i_s_tuser);
                smp = i_s_tdata[SAMPLE_W-1:0];
                if (!pair_open || open_axis != ax) begin
                    // new pair starts; a lone sample of the other axis is dropped
                    pair_open   = 1'b1;
                    open_axis   = ax;
                    open_sample = smp;
                end else begin
                    pair_open = 1'b0;
                    diff = (open_sample > smp) ? int'(open_sample) - int'(smp)
                                               : int'(smp) - int'(open_sample);
                    if (diff <= PAIR_LIMIT) begin
                        if (ax == AXIS_X) begin
                            x_avg   = SAMPLE_W'((int'(open_sample) + int'(smp)) >> 1);
                            x_valid = 1'b1;
                        end else if (x_valid) begin
                            x_valid = 1'b0;
                            want.x  = scale_to_pixel(x_avg, cal.x_gain, cal.x_offset, X_MAX);
                            want.y  = scale_to_pixel(
                                SAMPLE_W'((int'(open_sample) + int'(smp)) >> 1),
                                cal.y_gain, cal.y_offset, Y_MAX);
                            want.in_rect = int'(want.x) >= int'(cal.rect_left) &&
                                int'(want.x) <= int'(cal.rect_left) + int'(cal.rect_width) &&
                                int'(want.y) >= int'(cal.rect_top) &&
                                int'(want.y) <= int'(cal.rect_top) + int'(cal.rect_height);
                            point_q.push_back(want);
                        end
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_points_owed <= point_q.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench top: sample stimulus, point sink, register writes and the verdict.
module tb;
    import tmap_pkg::*;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int SETTLE_CYCLES   = 8;     // drain margin after the last owed point
    localparam int HOLD_CYCLES     = 150;   // long sink hold-off under pressure
    localparam int MAX_SAMPLE      = 4095;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;   // [11:0] sample, [15:12] zero
    logic                 i_s_tuser  = 1'b0; // [0] axis
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;         // [8:0] x_pixel, [17:9] y_pixel, [23:18] zero
    logic                 o_m_tuser;         // [0] inside_res
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [APB_AW-1:0]    paddr      = '0;
    logic [APB_DW-1:0]    pwdata     = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int   fail_count;
    int   points_owed;
    int   idle_pct   = 0;     // sender gap odds, read by the stimulus only
    int   stall_pct  = 0;     // sink stall odds, set with NBA
    logic hold_req   = 1'b0;  // rising edge starts a long sink hold-off
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;

    touch_sample_to_pixel_mapper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    tmap_point_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_points_owed (points_owed)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Point sink: random stalls, plus one long hold-off counted here so the
    // point queue fills and the sample side backs up.
    always @(posedge i_clk) begin : sink
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end else if (!hold_req) begin
            hold_seen = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one sample word, with random gaps in front, and wait for it to go in.
    task automatic send_word(input t_axis ax, input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'(smp);
        i_s_tuser  <= ax;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Mostly uniform, with the rails now and then.
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        if ($urandom_range(7) == 0) begin
            return $urandom_range(1) ? SAMPLE_W'(MAX_SAMPLE) : '0;
        end
        return SAMPLE_W'($urandom_range(MAX_SAMPLE));
    endfunction

    // Second sample of a pair: usually within the match window, sometimes outside.
    function automatic logic [SAMPLE_W-1:0] partner(input logic [SAMPLE_W-1:0] first);
        int d;
        if ($urandom_range(9) == 0) begin
            d = int'($urandom_range(400, PAIR_LIMIT + 1));
        end else begin
            d = int'($urandom_range(2 * PAIR_LIMIT)) - PAIR_LIMIT;
        end
        if ($urandom_range(1)) d = -d;
        d += int'(first);
        if (d < 0) d = 0;
        if (d > MAX_SAMPLE) d = MAX_SAMPLE;
        return SAMPLE_W'(d);
    endfunction

    task automatic send_pair(input t_axis ax);
        logic [SAMPLE_W-1:0] first;
        first = rand_sample();
        send_word(ax, first);
        send_word(ax, partner(first));
    endtask

    // One register write: setup cycle, then access until pready.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // Stop offering, wait for every owed point, then let the pipe drain.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (points_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [APB_DW-1:0] cal_word [8];
        int                sent;
        int                pick;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words on reset calibration, no idling.
        // Y pair with no X average held: no point
        send_word(AXIS_Y, 100);
        send_word(AXIS_Y, 120);
        // zero pairs: point at the origin, inside the empty rectangle
        send_word(AXIS_X, 0);
        send_word(AXIS_X, 0);
        send_word(AXIS_Y, 0);
        send_word(AXIS_Y, 0);
        // X pair exactly at the match limit is kept
        send_word(AXIS_X, 4095);
        send_word(AXIS_X, 4045);
        // Y pair one over the limit is dropped, X average stays
        send_word(AXIS_Y, 4095);
        send_word(AXIS_Y, 4044);
        // re-read Y pair completes the point, both axes clamp at the top
        send_word(AXIS_Y, 4095);
        send_word(AXIS_Y, 4095);
        // axis change inside a pair: the X word is dropped, then Y pair with no X
        send_word(AXIS_X, 2000);
        send_word(AXIS_Y, 2000);
        send_word(AXIS_Y, 2010);
        // newer X pair replaces the older one
        send_word(AXIS_X, 1000);
        send_word(AXIS_X, 1002);
        send_word(AXIS_X, 3000);
        send_word(AXIS_X, 3001);
        send_word(AXIS_Y, 2047);
        send_word(AXIS_Y, 2048);

        for (int p = 0; p < PHASES; p++) begin
            settle();

            // calibration sets: in-screen, top rails, bottom rails, raw random, mirrored
            case (p % 5)
                0: begin
                    cal_word[REG_X_GAIN]      = $urandom_range(1500, 900);
                    cal_word[REG_X_OFFSET]    = int'($urandom_range(80)) - 40;
                    cal_word[REG_Y_GAIN]      = $urandom_range(2200, 1700);
                    cal_word[REG_Y_OFFSET]    = int'($urandom_range(80)) - 40;
                    cal_word[REG_RECT_LEFT]   = $urandom_range(X_MAX);
                    cal_word[REG_RECT_TOP]    = $urandom_range(Y_MAX);
                    cal_word[REG_RECT_WIDTH]  = $urandom_range(X_MAX);
                    cal_word[REG_RECT_HEIGHT] = $urandom_range(Y_MAX);
                end
                1: begin
                    cal_word[REG_X_GAIN]      = 32'h7FFF;
                    cal_word[REG_X_OFFSET]    = 32'h7FF;
                    cal_word[REG_Y_GAIN]      = 32'h7FFF;
                    cal_word[REG_Y_OFFSET]    = 32'h7FF;
                    // rectangle past the screen edge
                    cal_word[REG_RECT_LEFT]   = 32'h1FF;
                    cal_word[REG_RECT_TOP]    = 32'h1FF;
                    cal_word[REG_RECT_WIDTH]  = 32'h1FF;
                    cal_word[REG_RECT_HEIGHT] = 32'h1FF;
                end
                2: begin
                    cal_word[REG_X_GAIN]      = 32'h8000;
                    cal_word[REG_X_OFFSET]    = 32'h800;
                    cal_word[REG_Y_GAIN]      = 32'h8000;
                    cal_word[REG_Y_OFFSET]    = 32'h800;
                    cal_word[REG_RECT_LEFT]   = '0;
                    cal_word[REG_RECT_TOP]    = '0;
                    cal_word[REG_RECT_WIDTH]  = '0;
                    cal_word[REG_RECT_HEIGHT] = '0;
                end
                3: begin
                    // full-width junk: only the low register bits may matter
                    for (int r = 0; r < 8; r++) cal_word[r] = $urandom();
                end
                default: begin
                    // negative gains with positive offsets: floor on negative products
                    cal_word[REG_X_GAIN]      = -int'($urandom_range(1500, 900));
                    cal_word[REG_X_OFFSET]    = $urandom_range(600, 300);
                    cal_word[REG_Y_GAIN]      = -int'($urandom_range(2200, 1700));
                    cal_word[REG_Y_OFFSET]    = $urandom_range(700, 480);
                    cal_word[REG_RECT_LEFT]   = $urandom_range(511);
                    cal_word[REG_RECT_TOP]    = $urandom_range(511);
                    cal_word[REG_RECT_WIDTH]  = $urandom_range(511);
                    cal_word[REG_RECT_HEIGHT] = $urandom_range(511);
                end
            endcase
            for (int r = 0; r < 8; r++) write_reg(t_reg_idx'(r), cal_word[r]);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;

            // idling: none, sender, sink, both
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  = 64;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct <= 64;
                end
                default: begin
                    idle_pct  = 16;
                    stall_pct <= 16;
                end
            endcase
            // back-pressure phase: sink holds off while samples keep coming
            if (p == 4) hold_req <= 1'b1;

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    // well-formed point: X pair then Y pair
                    send_pair(AXIS_X);
                    send_pair(AXIS_Y);
                    sent += 4;
                end else if (pick < 85) begin
                    // Y re-read, or Y with no X held
                    send_pair(AXIS_Y);
                    sent += 2;
                end else if (pick < 92) begin
                    // X pair that replaces the held average
                    send_pair(AXIS_X);
                    sent += 2;
                end else begin
                    // stray word that shifts the pairing
                    send_word(t_axis'($urandom_range(1)), rand_sample());
                    sent += 1;
                end
            end
            if (p == 4) hold_req <= 1'b0;
        end

        settle();
        if (fail_count == 0) begin
            $display("touch_sample_to_pixel_mapper test passed");
        end else begin
            $display("touch_sample_to_pixel_mapper test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("touch_sample_to_pixel_mapper test failed");
        $finish;
    end

endmodule
